FILE: rtl/ctkd_pkg.sv
`default_nettype none
package ctkd_pkg;

  // Defaults for the top-level parameters
  localparam int CAL_SAMPLES_DEF   = 10;
  localparam int TRIM_EACH_END_DEF = 2;
  localparam int COUNT_MAX_DEF     = 65535;

  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_RELOAD        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE_NORMAL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE_CONTINUOUS = 3'd4;

  // Register reset values
  localparam logic [15:0] GATE_THRESHOLD_RST        = 16'd80;
  localparam logic [2:0]  HOLDOFF_RELOAD_RST        = 3'd5;
  localparam logic [2:0]  RELEASE_LEVEL_RST         = 3'd2;
  localparam logic [2:0]  GROUP_SIZE_NORMAL_RST     = 3'd3;
  localparam logic [2:0]  GROUP_SIZE_CONTINUOUS_RST = 3'd6;

  // Scan phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // Input kind / result kind codes
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_CAL  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] charge_count;
    logic        continuous_mode;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic        touched;
    logic        calibration_failed;
    logic [15:0] baseline_value;
    logic [15:0] group_maximum;
  } out_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;     // latch input beat
    logic cal_insert;  // insert calibration count into sorted store
    logic sum_start;   // clear accumulator, point at first kept entry
    logic sum_step;    // add one sorted entry
    logic div_step;    // reciprocal multiply, latch the mean
    logic scan_apply;  // commit scan state update
    logic cal_load;    // commit baseline, load calibration result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_cal;
    logic cal_last;
    logic scan_result;
    logic sum_last;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/ctkd_dp.sv
`default_nettype none
module ctkd_dp #(
  parameter int CAL_SAMPLES   = 10,
  parameter int TRIM_EACH_END = 2,
  parameter int COUNT_MAX     = 65535
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ctkd_pkg::in_t               in_data,
  input  wire logic                        cfg_we,
  input  wire logic [ctkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ctkd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire ctkd_pkg::cmd_t              cmd,
  output ctkd_pkg::status_t                status,
  output ctkd_pkg::out_t                   out_data
);
  import ctkd_pkg::*;

  localparam int LO   = (2 * TRIM_EACH_END < CAL_SAMPLES) ? TRIM_EACH_END : 0;
  localparam int HI   = (2 * TRIM_EACH_END < CAL_SAMPLES) ? CAL_SAMPLES - TRIM_EACH_END
                                                          : CAL_SAMPLES;
  localparam int NAVG = HI - LO;
  localparam int IW   = $clog2(CAL_SAMPLES);
  localparam int SUMW = COUNT_W + $clog2(CAL_SAMPLES);
  // Reciprocal of the kept-entry count, rounded up; RK leaves enough fraction
  // bits that the product's upper bits are the exact floor mean for any sum.
  localparam int RK   = SUMW + $clog2(NAVG);
  localparam int PW   = SUMW + RK + 1;
  localparam logic [RK:0] RECIP = (RK+1)'(((longint'(1) << RK) + longint'(NAVG)
                                           - longint'(1)) / longint'(NAVG));
  localparam logic [15:0] CMAX = 16'(COUNT_MAX);
  localparam logic [15:0] HALF = 16'(COUNT_MAX / 2);

  // Config registers
  logic [15:0] gate_threshold;
  logic [2:0]  holdoff_reload;
  logic [2:0]  release_level;
  logic [2:0]  group_size_normal;
  logic [2:0]  group_size_continuous;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_threshold        <= GATE_THRESHOLD_RST;
      holdoff_reload        <= HOLDOFF_RELOAD_RST;
      release_level         <= RELEASE_LEVEL_RST;
      group_size_normal     <= GROUP_SIZE_NORMAL_RST;
      group_size_continuous <= GROUP_SIZE_CONTINUOUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GATE_THRESHOLD:        gate_threshold        <= cfg_data;
        REG_HOLDOFF_RELOAD:        holdoff_reload        <= cfg_data[2:0];
        REG_RELEASE_LEVEL:         release_level         <= cfg_data[2:0];
        REG_GROUP_SIZE_NORMAL:     group_size_normal     <= cfg_data[2:0];
        REG_GROUP_SIZE_CONTINUOUS: group_size_continuous <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Input beat register
  in_t in_q;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= in_data;
    end
  end

  logic [15:0] count_sat;
  assign count_sat = (in_q.charge_count > CMAX) ? CMAX : in_q.charge_count;

  // ---------------- Calibration: insertion-sorted store ----------------
  logic [15:0]   sorted [CAL_SAMPLES];
  logic [15:0]   sorted_next [CAL_SAMPLES];
  logic [CAL_SAMPLES-1:0] le;
  logic [IW-1:0] cal_idx;

  always_comb begin
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      le[i] = (IW'(i) < cal_idx) && (sorted[i] <= count_sat);
    end
    sorted_next[0] = le[0] ? sorted[0] : count_sat;
    for (int i = 1; i < CAL_SAMPLES; i++) begin
      if (le[i]) begin
        sorted_next[i] = sorted[i];
      end else if (le[i-1]) begin
        sorted_next[i] = count_sat;
      end else begin
        sorted_next[i] = sorted[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cal_insert) begin
      for (int i = 0; i < CAL_SAMPLES; i++) begin
        sorted[i] <= sorted_next[i];
      end
    end
  end

  logic cal_last;
  assign cal_last = (cal_idx == IW'(CAL_SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_idx <= '0;
    end else if (cmd.cal_insert) begin
      cal_idx <= cal_last ? '0 : cal_idx + 1'b1;
    end
  end

  // Trimmed sum, one entry per cycle
  logic [SUMW-1:0] acc;
  logic [SUMW-1:0] acc_next;
  logic [IW-1:0]   sum_ptr;
  logic            sum_last;
  assign acc_next = acc + SUMW'(sorted[sum_ptr]);
  assign sum_last = (sum_ptr == IW'(HI - 1));

  // Mean by reciprocal multiply, latched in the cycle after the sum is complete
  logic [PW-1:0]   prod;
  logic [15:0]     quo;
  assign prod = PW'(acc) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      acc     <= '0;
      sum_ptr <= IW'(LO);
    end else if (cmd.sum_step) begin
      acc     <= acc_next;
      sum_ptr <= sum_ptr + 1'b1;
    end else if (cmd.div_step) begin
      quo     <= prod[RK +: 16];
    end
  end

  // ---------------- Scan path ----------------
  logic [15:0] baseline;
  logic [2:0]  holdoff;
  logic [1:0]  phase;
  logic [2:0]  pos;
  logic [15:0] run_max;
  logic [2:0]  latched_size;

  logic        first;
  logic [2:0]  size_pick;
  logic [2:0]  size_eff;
  logic [2:0]  hold0;
  logic [15:0] max0;
  logic [15:0] max_new;
  logic [2:0]  pos_new;
  logic        group_end;
  logic [16:0] limit;
  logic        above;
  logic [1:0]  phase_cur;
  logic        to_second;
  logic        scan_result;
  logic        touch;
  logic [2:0]  hold_pre;
  logic [2:0]  hold_fin;

  always_comb begin
    first     = (phase == PH_IDLE);
    size_pick = in_q.continuous_mode ? group_size_continuous : group_size_normal;
    size_eff  = first ? ((size_pick == 3'd0) ? 3'd1 : size_pick) : latched_size;
    hold0     = (first && in_q.continuous_mode) ? 3'd0 : holdoff;
    max0      = first ? 16'd0 : run_max;
    max_new   = (count_sat > max0) ? count_sat : max0;
    pos_new   = (first ? 3'd0 : pos) + 3'd1;
    group_end = (pos_new >= size_eff);
    limit     = {1'b0, baseline} + {1'b0, gate_threshold};
    above     = ({1'b0, max_new} > limit);
    phase_cur = first ? PH_FIRST : phase;
    to_second = (phase_cur == PH_FIRST) && above;
    scan_result = group_end && !to_second;
    if (phase_cur == PH_FIRST) begin
      touch    = 1'b0;
      hold_pre = (hold0 > release_level) ? release_level : hold0;
    end else begin
      touch    = (hold0 == 3'd0) && above;
      hold_pre = holdoff_reload;
    end
    hold_fin = (hold_pre != 3'd0) ? hold_pre - 3'd1 : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff      <= '0;
      phase        <= PH_IDLE;
      pos          <= '0;
      run_max      <= '0;
      latched_size <= '0;
    end else if (cmd.scan_apply) begin
      latched_size <= size_eff;
      if (!group_end) begin
        phase   <= phase_cur;
        pos     <= pos_new;
        run_max <= max_new;
        holdoff <= hold0;
      end else begin
        pos     <= '0;
        run_max <= '0;
        if (to_second) begin
          phase   <= PH_SECOND;
          holdoff <= hold0;
        end else begin
          phase   <= PH_IDLE;
          holdoff <= hold_fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
    end else if (cmd.cal_load) begin
      baseline <= quo;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.cal_load) begin
      out_data.result_kind        <= KIND_CAL;
      out_data.touched            <= 1'b0;
      out_data.calibration_failed <= (quo > HALF);
      out_data.baseline_value     <= quo;
      out_data.group_maximum      <= 16'd0;
    end else if (cmd.scan_apply && scan_result) begin
      out_data.result_kind        <= KIND_SCAN;
      out_data.touched            <= touch;
      out_data.calibration_failed <= 1'b0;
      out_data.baseline_value     <= baseline;
      out_data.group_maximum      <= max_new;
    end
  end

  always_comb begin
    status.is_cal      = (in_q.kind == KIND_CAL);
    status.cal_last    = cal_last;
    status.scan_result = scan_result;
    status.sum_last    = sum_last;
  end

  // Group position always stays below the latched group size mid-scan
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (pos < latched_size))
    else $error("group position reached latched group size");

endmodule
`default_nettype wire

FILE: rtl/ctkd_ctrl.sv
`default_nettype none
module ctkd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ctkd_pkg::status_t status,
  output ctkd_pkg::cmd_t         cmd
);
  import ctkd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_CALOUT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;
  logic       out_load;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_cal) begin
          cmd.cal_insert = 1'b1;
          if (status.cal_last) begin
            cmd.sum_start = 1'b1;
            state_next    = ST_SUM;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (!status.scan_result || slot_free) begin
          cmd.scan_apply = 1'b1;
          out_load       = status.scan_result;
          state_next     = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = ST_CALOUT;
      end
      ST_CALOUT: begin
        if (slot_free) begin
          cmd.cal_load = 1'b1;
          out_load     = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result overwritten while waiting");

  // Averaging only follows the last calibration beat
  a_sum_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> ($past(state) == ST_EXEC || $past(state) == ST_SUM))
    else $error("sum phase entered out of sequence");

  // A calibration result comes only after the mean has been formed
  a_calout_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALOUT) |-> ($past(state) == ST_DIV || $past(state) == ST_CALOUT))
    else $error("calibration result without divide");

endmodule
`default_nettype wire

FILE: rtl/capacitive_touch_key_detector.sv
`default_nettype none
// Capacitive touch key detector (charge-time method). Each input beat is one
// charge-time count, tagged as scan or calibration. Calibration counts are
// insertion-sorted into a CAL_SAMPLES-entry register row as they arrive; the
// last one triggers a trimmed mean (TRIM_EACH_END dropped at each end) that
// becomes the new baseline and yields a calibration result, flagged as failed
// when the baseline exceeds COUNT_MAX/2. Scan counts form groups (size from
// the group-size registers, chosen by continuous_mode at the first count of a
// scan); a first group above baseline + gate_threshold starts a second group
// that decides the touch, with a hold-off counter suppressing repeats.
// Sequencing: a scan count or a non-final calibration count is captured and
// then executed before the block is ready again. The final calibration count
// also runs the one-entry-per-cycle summation, a reciprocal multiply for the
// mean and the result load. A result waiting in the output register only
// holds up the block when the next beat itself produces a result.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect on the next beat; write them only while the block is idle.
module capacitive_touch_key_detector #(
  parameter int CAL_SAMPLES   = ctkd_pkg::CAL_SAMPLES_DEF,
  parameter int TRIM_EACH_END = ctkd_pkg::TRIM_EACH_END_DEF,
  parameter int COUNT_MAX     = ctkd_pkg::COUNT_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ctkd_pkg::in_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ctkd_pkg::out_t                       out_data,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [ctkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ctkd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctkd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: accept, execute, and for the last calibration beat the
  // sum / divide / publish steps.
  ctkd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Config registers, sorted store, accumulator, divider, scan state and
  // the result register.
  ctkd_dp #(
    .CAL_SAMPLES   (CAL_SAMPLES),
    .TRIM_EACH_END (TRIM_EACH_END),
    .COUNT_MAX     (COUNT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/capacitive_touch_key_detector_tb.sv
`timescale 1ns / 100ps

module capacitive_touch_key_detector_tb;
  import ctkd_pkg::*;

  localparam int CAL_N      = CAL_SAMPLES_DEF;
  localparam int TRIM       = TRIM_EACH_END_DEF;
  localparam int FULL_SCALE = COUNT_MAX_DEF;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 140;
  // leave margin for the final calibration count before touching regs
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  // Scoreboard: own copy of the detector state plus the queue of reports
  // the block still owes us.
  class touch_scoreboard;
    // register copies
    bit [15:0] gate_thr;
    bit [2:0]  holdoff_load;
    bit [2:0]  rel_level;
    bit [2:0]  size_norm;
    bit [2:0]  size_cont;
    // detector state
    bit [15:0] cal_store [CAL_N];
    int        cal_idx;
    bit [15:0] base_cnt;
    bit [2:0]  holdoff;
    logic [1:0] scan_ph;
    int        grp_pos;
    int        grp_size;
    bit [15:0] run_max;

    out_t due_reports [$];
    int   mismatches;
    int   scan_reports;
    int   touches;
    int   cal_reports;
    int   cal_over_half;

    function new();
      gate_thr     = GATE_THRESHOLD_RST;
      holdoff_load = HOLDOFF_RELOAD_RST;
      rel_level    = RELEASE_LEVEL_RST;
      size_norm    = GROUP_SIZE_NORMAL_RST;
      size_cont    = GROUP_SIZE_CONTINUOUS_RST;
      cal_idx      = 0;
      base_cnt     = '0;
      holdoff      = '0;
      scan_ph      = PH_IDLE;
      grp_pos      = 0;
      grp_size     = 0;
      run_max      = '0;
      mismatches   = 0;
      scan_reports = 0;
      touches      = 0;
      cal_reports  = 0;
      cal_over_half = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GATE_THRESHOLD:        gate_thr     = val;
        REG_HOLDOFF_RELOAD:        holdoff_load = val[2:0];
        REG_RELEASE_LEVEL:         rel_level    = val[2:0];
        REG_GROUP_SIZE_NORMAL:     size_norm    = val[2:0];
        REG_GROUP_SIZE_CONTINUOUS: size_cont    = val[2:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted count; queue the report it causes, if any.
    function void take_count(in_t b);
      bit [15:0]       sorted [CAL_N];
      bit [15:0]       v;
      int              i;
      int              j;
      int              lo;
      int              hi;
      longint unsigned sum;
      int unsigned     lim;
      bit [15:0]       gmax;
      bit              hit;
      out_t            rep;

      if (b.kind == KIND_CAL) begin
        cal_store[cal_idx] = b.charge_count;
        cal_idx++;
        if (cal_idx >= CAL_N) begin
          cal_idx = 0;
          // insertion sort, then trimmed floor mean
          for (i = 0; i < CAL_N; i++) begin
            v = cal_store[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
              sorted[j] = sorted[j-1];
              j--;
            end
            sorted[j] = v;
          end
          if (2 * TRIM < CAL_N) begin
            lo = TRIM;
            hi = CAL_N - TRIM;
          end else begin
            lo = 0;
            hi = CAL_N;
          end
          sum = 0;
          for (i = lo; i < hi; i++)
            sum += 64'(sorted[i]);
          base_cnt = 16'(sum / longint'(hi - lo));
          rep.result_kind        = KIND_CAL;
          rep.touched            = 1'b0;
          rep.calibration_failed = (base_cnt > FULL_SCALE / 2);
          rep.baseline_value     = base_cnt;
          rep.group_maximum      = '0;
          due_reports.push_back(rep);
        end
      end else begin
        if (scan_ph == PH_IDLE) begin
          grp_size = b.continuous_mode ? int'(size_cont) : int'(size_norm);
          if (grp_size == 0)
            grp_size = 1;
          if (b.continuous_mode)
            holdoff = '0;
          scan_ph = PH_FIRST;
          grp_pos = 0;
          run_max = '0;
        end
        if (b.charge_count > run_max)
          run_max = b.charge_count;
        grp_pos++;
        if (grp_pos >= grp_size) begin
          gmax    = run_max;
          lim     = 32'(base_cnt) + 32'(gate_thr);   // 17-bit sum, no wrap
          grp_pos = 0;
          run_max = '0;
          if (scan_ph == PH_FIRST && gmax > lim) begin
            scan_ph = PH_SECOND;
          end else begin
            if (scan_ph == PH_FIRST) begin
              if (holdoff > rel_level)
                holdoff = rel_level;
              hit = 1'b0;
            end else begin
              hit     = (holdoff == 0) && (gmax > lim);
              holdoff = holdoff_load;
            end
            if (holdoff != 0)
              holdoff--;
            scan_ph = PH_IDLE;
            rep.result_kind        = KIND_SCAN;
            rep.touched            = hit;
            rep.calibration_failed = 1'b0;
            rep.baseline_value     = base_cnt;
            rep.group_maximum      = gmax;
            due_reports.push_back(rep);
          end
        end
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected report kind=%0d touched=%0d cal_fail=%0d base=%0d max=%0d",
                   $time, got.result_kind, got.touched, got.calibration_failed,
                   got.baseline_value, got.group_maximum);
      end else begin
        want = due_reports.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: report mismatch, expected kind=%0d touched=%0d cal_fail=%0d base=%0d max=%0d",
                     $time, want.result_kind, want.touched, want.calibration_failed,
                     want.baseline_value, want.group_maximum);
            $display("%0t:                  actual kind=%0d touched=%0d cal_fail=%0d base=%0d max=%0d",
                     $time, got.result_kind, got.touched, got.calibration_failed,
                     got.baseline_value, got.group_maximum);
          end
        end
        if (got.result_kind == KIND_CAL) begin
          cal_reports++;
          if (got.calibration_failed)
            cal_over_half++;
        end else begin
          scan_reports++;
          if (got.touched)
            touches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_scoreboard sb;
  int send_idle_pct;   // chance per cycle that the count source holds back
  int recv_idle_pct;   // chance per cycle that the report sink stalls
  int beats_sent;
  int cycle_count;

  capacitive_touch_key_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost report ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still owed",
               cycle_count, sb.due_reports.size());
      $display("capacitive_touch_key_detector regression: fail");
      $finish;
    end
  end

  // Offer one count. Valid may drop only while no beat is pending; once
  // raised it holds with the same payload until the block takes it.
  task automatic send_beat(logic k, logic [15:0] c, logic m);
    in_t b;
    b.kind            = k;
    b.charge_count    = c;
    b.continuous_mode = m;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.take_count(b);
    beats_sent++;
  endtask

  // Hold the source off until every owed report is in, then optionally
  // give the block extra cycles to finish work that reports nothing.
  task automatic wait_drained(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_reports.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(logic [15:0] gate, logic [2:0] hold, logic [2:0] rel,
                                logic [2:0] size_n, logic [2:0] size_c);
    put_reg(REG_GATE_THRESHOLD, gate);
    put_reg(REG_HOLDOFF_RELOAD, {13'd0, hold});
    put_reg(REG_RELEASE_LEVEL, {13'd0, rel});
    put_reg(REG_GROUP_SIZE_NORMAL, {13'd0, size_n});
    put_reg(REG_GROUP_SIZE_CONTINUOUS, {13'd0, size_c});
    cfg_we <= 1'b0;
  endtask

  // Calibration count clustered above a base, with the odd outlier that
  // the trimming should throw away.
  function automatic logic [15:0] cal_count(int cbase);
    int v;
    if ($urandom_range(0, 9) == 0)
      v = $urandom_range(0, 65535);
    else
      v = cbase + int'($urandom_range(0, 40));
    if (v > FULL_SCALE)
      v = FULL_SCALE;
    return v[15:0];
  endfunction

  // Scan count aimed at the current touch threshold: most often right around
  // it, otherwise clearly below, clearly above, at the rails or anywhere.
  function automatic logic [15:0] scan_count(int lim);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 30)
      v = lim + int'($urandom_range(0, 6)) - 3;
    else if (r < 55)
      v = $urandom_range(0, (lim > FULL_SCALE) ? FULL_SCALE : lim);
    else if (r < 75)
      v = (lim < FULL_SCALE) ? int'($urandom_range(lim + 1, FULL_SCALE)) : FULL_SCALE;
    else if (r < 85)
      v = $urandom_range(0, 1) ? FULL_SCALE : 0;
    else
      v = $urandom_range(0, 65535);
    if (v < 0)
      v = 0;
    if (v > FULL_SCALE)
      v = FULL_SCALE;
    return v[15:0];
  endfunction

  initial begin : result_sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1)
        sb.check_result(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    int          ph;
    int          n;
    int          r;
    int          cbase;
    logic [15:0] g;
    logic [2:0]  hr;
    logic [2:0]  rl;
    logic [2:0]  gn;
    logic [2:0]  gc;
    bit          failed;

    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    beats_sent  = 0;
    cycle_count = 0;
    send_idle_pct = 30;
    recv_idle_pct = 53;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset register values ----
    // quiet pad: first group at zero, baseline zero -> no touch
    repeat (3) send_beat(KIND_SCAN, 16'd0, 1'b0);
    // full-scale first group, second group just one above the gate -> touch
    send_beat(KIND_SCAN, 16'hFFFF, 1'b0);
    send_beat(KIND_SCAN, 16'd1, 1'b0);
    send_beat(KIND_SCAN, 16'd2, 1'b0);
    send_beat(KIND_SCAN, 16'd81, 1'b0);
    send_beat(KIND_SCAN, 16'd0, 1'b0);
    send_beat(KIND_SCAN, 16'd0, 1'b0);
    // release right after the touch: hold-off gets cut to the release level
    repeat (3) send_beat(KIND_SCAN, 16'd0, 1'b0);
    // calibration slipped into the middle of a scan; all-max counts push the
    // baseline past half scale, and baseline + gate no longer fits 16 bits
    send_beat(KIND_SCAN, 16'd5, 1'b0);
    repeat (10) send_beat(KIND_CAL, 16'hFFFF, 1'b0);
    send_beat(KIND_SCAN, 16'd3, 1'b0);
    send_beat(KIND_SCAN, 16'd2, 1'b0);

    // ---- random part: one register setting per phase ----
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 53;
      end else if (ph < 6) begin
        send_idle_pct = 53;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained(SETTLE_CYCLES);

      // a zero group size behaves as one; gate extremes make touches
      // trivially easy (0) or impossible (full scale)
      case (ph)
        0: begin g = 16'd80;    hr = 3'd5; rl = 3'd2; gn = 3'd3; gc = 3'd6; cbase = 100;   end
        1: begin g = 16'd0;     hr = 3'd0; rl = 3'd7; gn = 3'd1; gc = 3'd7; cbase = 0;     end
        2: begin g = 16'hFFFF;  hr = 3'd7; rl = 3'd0; gn = 3'd7; gc = 3'd1; cbase = 40000; end
        3: begin g = 16'd200;   hr = 3'd3; rl = 3'd1; gn = 3'd0; gc = 3'd0; cbase = 1000;  end
        5: begin g = 16'd1;     hr = 3'd7; rl = 3'd0; gn = 3'd2; gc = 3'd4; cbase = 60000; end
        6: begin g = 16'd3000;  hr = 3'd1; rl = 3'd7; gn = 3'd7; gc = 3'd2; cbase = 20000; end
        default: begin
          g     = 16'($urandom_range(0, 65535));
          hr    = 3'($urandom_range(0, 7));
          rl    = 3'($urandom_range(0, 7));
          gn    = 3'($urandom_range(0, 7));
          gc    = 3'($urandom_range(0, 7));
          cbase = $urandom_range(0, 65535);
        end
      endcase
      apply_settings(g, hr, rl, gn, gc);

      // fresh baseline for this setting
      repeat (CAL_N) send_beat(KIND_CAL, cal_count(cbase), 1'($urandom_range(0, 1)));

      for (n = 0; n < PHASE_BEATS; n++) begin
        r = $urandom_range(0, 99);
        if (r == 0)
          wait_drained(0);
        if (r < 3) begin
          // full recalibration, sometimes around a new level
          if ($urandom_range(0, 1))
            cbase = $urandom_range(0, 65535);
          repeat (CAL_N) send_beat(KIND_CAL, cal_count(cbase), 1'($urandom_range(0, 1)));
        end else if (r < 8) begin
          send_beat(KIND_CAL, cal_count(cbase), 1'($urandom_range(0, 1)));
        end else begin
          send_beat(KIND_SCAN, scan_count(int'(sb.base_cnt) + int'(sb.gate_thr)),
                    ($urandom_range(0, 99) < 30));
        end
      end
    end

    wait_drained(SETTLE_CYCLES);

    $display("ran %0d count beats over %0d register settings with varied back-pressure",
             beats_sent, PHASES + 1);
    $display("checked %0d scan reports (%0d touches) and %0d calibrations (%0d over half scale)",
             sb.scan_reports, sb.touches, sb.cal_reports, sb.cal_over_half);
    failed = (sb.mismatches != 0) || (sb.due_reports.size() != 0);
    if (!failed)
      $display("capacitive_touch_key_detector regression: pass");
    else begin
      $display("%0d mismatching reports, %0d still owed", sb.mismatches,
               sb.due_reports.size());
      $display("capacitive_touch_key_detector regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ctkd_pkg.sv
rtl/ctkd_dp.sv
rtl/ctkd_ctrl.sv
rtl/capacitive_touch_key_detector.sv
tb/capacitive_touch_key_detector_tb.sv
